[hdl/bmf_pkg.sv]
// Shared constants, controller states and control/status bundles of the box mean filter.
package bmf_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_MAX_RADIUS = 3;

  localparam int CH_W     = 8;
  localparam int PIX_W    = 24;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 11;
  localparam int POS_W    = 10;
  localparam int OUT_DW   = 48;

  localparam logic [CFG_AW-1:0] REG_WIDTH  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_HEIGHT = 2'd1;
  localparam logic [CFG_AW-1:0] REG_RADIUS = 2'd2;
  localparam logic [CFG_AW-1:0] REG_COLOR  = 2'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SUM,
    ST_FLUSH,
    ST_LOAD,
    ST_DIV,
    ST_FIN,
    ST_OUT
  } bmf_state_t;

  typedef struct packed {
    logic accept;
    logic eval;
    logic sum_init;
    logic issue;
    logic div_init;
    logic div_step;
    logic out_load;
  } bmf_cmd_t;

  typedef struct packed {
    logic ready;
    logic bad;
    logic issue_last;
    logic div_last;
  } bmf_status_t;

endpackage

[hdl/bmf_ctrl.sv]
// Controller state machine: sequences accept, window sum, divide and result hold.
module bmf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_fire,
  input  logic                 out_tready,
  input  bmf_pkg::bmf_status_t sts,
  output bmf_pkg::bmf_cmd_t    cmd,
  output logic                 in_tready,
  output logic                 out_tvalid
);
  import bmf_pkg::*;

  bmf_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_fire) state_nxt = ST_EVAL;
      ST_EVAL:  state_nxt = (sts.ready && !sts.bad) ? ST_SUM : ST_IDLE;
      ST_SUM:   if (sts.issue_last) state_nxt = ST_FLUSH;
      ST_FLUSH: state_nxt = ST_LOAD;
      ST_LOAD:  state_nxt = ST_DIV;
      ST_DIV:   if (sts.div_last) state_nxt = ST_FIN;
      ST_FIN:   state_nxt = ST_OUT;
      ST_OUT:   if (out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.accept = in_fire;
      end
      ST_EVAL: begin
        cmd.eval     = 1'b1;
        cmd.sum_init = sts.ready && !sts.bad;
      end
      ST_SUM:   cmd.issue    = 1'b1;
      ST_FLUSH: ;
      ST_LOAD:  cmd.div_init = 1'b1;
      ST_DIV:   cmd.div_step = 1'b1;
      ST_FIN:   cmd.out_load = 1'b1;
      ST_OUT:   out_tvalid   = 1'b1;
      default:  ;
    endcase
  end

endmodule

[hdl/bmf_datapath.sv]
// Datapath: config registers, frame counters, line store, window accumulator, divider.
module bmf_datapath #(
  parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = bmf_pkg::DEF_MAX_RADIUS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bmf_pkg::bmf_cmd_t           cmd,
  output bmf_pkg::bmf_status_t        sts,
  input  logic                        cfg_fire,
  input  logic [bmf_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [bmf_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                        in_op,
  input  logic [bmf_pkg::PIX_W-1:0]   in_pix,
  output logic [bmf_pkg::OUT_DW-1:0]  out_data,
  output logic                        out_last
);
  import bmf_pkg::*;

  localparam int LINE_ROWS = 2 * MAX_RADIUS + 2;
  localparam int SLOT_W    = $clog2(LINE_ROWS);
  localparam int COL_W     = $clog2(MAX_WIDTH + 1);
  localparam int ROW_W     = $clog2(MAX_HEIGHT + 1);
  localparam int RAD_W     = $clog2(MAX_RADIUS + 1);
  localparam int CELLS     = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int SUM_W     = $clog2(CELLS * 255 + 1);
  localparam int CNT_W     = $clog2(CELLS + 1);
  localparam int DEPTH     = LINE_ROWS * MAX_WIDTH;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int IDX_W     = $clog2(SUM_W);
  localparam int CMP_W     = 13;

  // configuration (stored already clamped)
  logic [COL_W-1:0] w_r;
  logic [ROW_W-1:0] h_r;
  logic [RAD_W-1:0] rad_r;
  logic             color_r;

  logic [CMP_W-1:0] cfg_ext;
  assign cfg_ext = CMP_W'(cfg_data);

  logic [ROW_W-1:0]  in_row_r, emit_row_r;
  logic [COL_W-1:0]  in_col_r, emit_col_r;
  logic [SLOT_W-1:0] in_slot_r, emit_slot_r;

  logic restart;
  logic last;
  assign last    = (emit_row_r == h_r - 1'b1) && (emit_col_r == w_r - 1'b1);
  assign restart = cfg_fire || (cmd.eval && sts.bad) || (cmd.out_load && last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r     <= (MAX_WIDTH < 1024) ? COL_W'(MAX_WIDTH) : COL_W'(1024);
      h_r     <= (MAX_HEIGHT < 1024) ? ROW_W'(MAX_HEIGHT) : ROW_W'(1024);
      rad_r   <= RAD_W'(1);
      color_r <= 1'b1;
    end else if (cfg_fire) begin
      unique case (cfg_addr)
        REG_WIDTH: begin
          if (cfg_ext == '0) w_r <= COL_W'(1);
          else if (cfg_ext > CMP_W'(MAX_WIDTH)) w_r <= COL_W'(MAX_WIDTH);
          else w_r <= COL_W'(cfg_ext);
        end
        REG_HEIGHT: begin
          if (cfg_ext == '0) h_r <= ROW_W'(1);
          else if (cfg_ext > CMP_W'(MAX_HEIGHT)) h_r <= ROW_W'(MAX_HEIGHT);
          else h_r <= ROW_W'(cfg_ext);
        end
        REG_RADIUS: begin
          if ({1'b0, cfg_data[1:0]} > 3'(MAX_RADIUS)) rad_r <= RAD_W'(MAX_RADIUS);
          else rad_r <= RAD_W'(cfg_data[1:0]);
        end
        REG_COLOR: color_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // write side
  logic wr_en;
  assign wr_en = cmd.accept && (in_op == OP_PIXEL) && (in_row_r < h_r) && (in_col_r < w_r);

  logic [PIX_W-1:0] wr_pix;
  assign wr_pix = color_r ? in_pix : {16'h0, in_pix[7:0]};

  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      in_row_r  <= '0;
      in_col_r  <= '0;
      in_slot_r <= '0;
    end else if (wr_en) begin
      if (in_col_r == w_r - 1'b1) begin
        in_col_r  <= '0;
        in_row_r  <= in_row_r + 1'b1;
        in_slot_r <= (in_slot_r == SLOT_W'(LINE_ROWS - 1)) ? '0 : in_slot_r + 1'b1;
      end else begin
        in_col_r <= in_col_r + 1'b1;
      end
    end
  end

  // window bounds of the pending output
  logic [ROW_W:0]   row_hi_ext;
  logic [COL_W:0]   col_hi_ext;
  logic [ROW_W-1:0] r_hi, r_lo;
  logic [COL_W-1:0] c_hi, c_lo;
  logic [SLOT_W-1:0] row_back, lo_slot;

  always_comb begin
    row_hi_ext = (ROW_W + 1)'(emit_row_r) + (ROW_W + 1)'(rad_r);
    col_hi_ext = (COL_W + 1)'(emit_col_r) + (COL_W + 1)'(rad_r);
    r_hi = (row_hi_ext > (ROW_W + 1)'(h_r - 1'b1)) ? h_r - 1'b1 : row_hi_ext[ROW_W-1:0];
    c_hi = (col_hi_ext > (COL_W + 1)'(w_r - 1'b1)) ? w_r - 1'b1 : col_hi_ext[COL_W-1:0];
    r_lo = (emit_row_r >= ROW_W'(rad_r)) ? emit_row_r - ROW_W'(rad_r) : '0;
    c_lo = (emit_col_r >= COL_W'(rad_r)) ? emit_col_r - COL_W'(rad_r) : '0;
    row_back = SLOT_W'(emit_row_r - r_lo);
    lo_slot = (emit_slot_r >= row_back) ? emit_slot_r - row_back
                                        : SLOT_W'(emit_slot_r + SLOT_W'(LINE_ROWS) - row_back);
  end

  assign sts.bad   = (emit_row_r >= h_r) || (emit_col_r >= w_r);
  assign sts.ready = (in_row_r >= h_r) || (in_row_r > r_hi) ||
                     ((in_row_r == r_hi) && (in_col_r > c_hi));

  // window walk
  logic [ROW_W-1:0]  q_r, rhi_r;
  logic [COL_W-1:0]  p_r, clo_r, chi_r;
  logic [SLOT_W-1:0] slot_r;

  assign sts.issue_last = (q_r == rhi_r) && (p_r == chi_r);

  always_ff @(posedge clk) begin
    if (cmd.sum_init) begin
      q_r    <= r_lo;
      rhi_r  <= r_hi;
      p_r    <= c_lo;
      clo_r  <= c_lo;
      chi_r  <= c_hi;
      slot_r <= lo_slot;
    end else if (cmd.issue) begin
      if (p_r == chi_r) begin
        p_r    <= clo_r;
        q_r    <= q_r + 1'b1;
        slot_r <= (slot_r == SLOT_W'(LINE_ROWS - 1)) ? '0 : slot_r + 1'b1;
      end else begin
        p_r <= p_r + 1'b1;
      end
    end
  end

  // line store
  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rd_data_r;
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic              rd_vld_r;

  assign wr_addr = ADDR_W'(ADDR_W'(in_slot_r) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(in_col_r);
  assign rd_addr = ADDR_W'(ADDR_W'(slot_r) * ADDR_W'(MAX_WIDTH)) + ADDR_W'(p_r);

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_pix;
    if (cmd.issue) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_vld_r <= 1'b0;
    else rd_vld_r <= cmd.issue;
  end

  // accumulate, then restoring divide on all channels at once
  logic [SUM_W-1:0] acc_r [3];
  logic [CNT_W-1:0] rem_r [3];
  logic [CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0] idx_r;

  assign sts.div_last = (idx_r == '0);

  for (genvar ch = 0; ch < 3; ch++) begin : g_ch
    logic [CNT_W:0] shifted;
    logic           ge;
    assign shifted = {rem_r[ch], acc_r[ch][SUM_W-1]};
    assign ge      = shifted >= {1'b0, cnt_r};

    always_ff @(posedge clk) begin
      if (cmd.sum_init) begin
        acc_r[ch] <= '0;
      end else if (rd_vld_r) begin
        acc_r[ch] <= acc_r[ch] + SUM_W'(rd_data_r[ch*CH_W +: CH_W]);
      end else if (cmd.div_step) begin
        acc_r[ch] <= {acc_r[ch][SUM_W-2:0], ge};
      end
      if (cmd.div_init) begin
        rem_r[ch] <= '0;
      end else if (cmd.div_step) begin
        rem_r[ch] <= ge ? CNT_W'(shifted - {1'b0, cnt_r}) : CNT_W'(shifted);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_init) cnt_r <= '0;
    else if (rd_vld_r) cnt_r <= cnt_r + 1'b1;
    if (cmd.div_init) idx_r <= IDX_W'(SUM_W - 1);
    else if (cmd.div_step) idx_r <= idx_r - 1'b1;
  end

  // emit counters and result register
  always_ff @(posedge clk) begin
    if (!rst_n || restart) begin
      emit_row_r  <= '0;
      emit_col_r  <= '0;
      emit_slot_r <= '0;
    end else if (cmd.out_load) begin
      if (emit_col_r == w_r - 1'b1) begin
        emit_col_r  <= '0;
        emit_row_r  <= emit_row_r + 1'b1;
        emit_slot_r <= (emit_slot_r == SLOT_W'(LINE_ROWS - 1)) ? '0 : emit_slot_r + 1'b1;
      end else begin
        emit_col_r <= emit_col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= {4'h0, POS_W'(emit_col_r), POS_W'(emit_row_r),
                   color_r ? acc_r[2][CH_W-1:0] : 8'h0,
                   color_r ? acc_r[1][CH_W-1:0] : 8'h0,
                   acc_r[0][CH_W-1:0]};
      out_last <= last;
    end
  end

endmodule

[hdl/box_mean_filter_core.sv]
// Top level of the box mean filter: stream ports, controller and datapath.
// Box mean filter over a raster pixel stream. Each result is the per-channel mean
// of the (2*radius+1) square window around one pixel, counting only cells inside
// the frame, rounded down. Send op=0 items for pixels and op=1 drain ticks after
// the frame to flush the outputs still owed; at most one result follows each
// input transfer, with frame_last set on the last pixel of the frame. The block
// handles one item at a time: an input transfer that yields a result is worked
// by the single line-store read port walking the window one cell per cycle and
// then by the one-bit-per-cycle restoring divider. The result register holds
// until taken. Config writes are taken any cycle, should come only while the
// block is idle, and restart the frame. The line store is not cleared after
// reset; it is only read where the frame has written.
module box_mean_filter_core #(
  parameter int MAX_WIDTH  = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = bmf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_RADIUS = bmf_pkg::DEF_MAX_RADIUS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [bmf_pkg::PIX_W-1:0]   in_tdata,   // pix_b, pix_g, pix_r
  input  logic                        in_tuser,   // op
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [bmf_pkg::OUT_DW-1:0]  out_tdata,  // pad, out_col, out_row, mean_b, mean_g, mean_r
  output logic                        out_tlast,  // frame_last
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [bmf_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [bmf_pkg::CFG_DW-1:0]  cfg_data
);
  import bmf_pkg::*;

  bmf_cmd_t    cmd;
  bmf_status_t sts;
  logic        in_fire;

  assign cfg_ready = 1'b1;
  assign in_fire   = in_tvalid && in_tready;

  bmf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_fire    (in_fire),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid)
  );

  bmf_datapath #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .cfg_fire (cfg_valid && cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .in_op    (in_tuser),
    .in_pix   (in_tdata),
    .out_data (out_tdata),
    .out_last (out_tlast)
  );

  // a pending result blocks new input
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input open while result pending");

  // an accepted item is worked before the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready) else $error("back-to-back accept");

  // a result transfer returns the block to accepting input
  a_out_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready) |=> (in_tready && !out_tvalid))
    else $error("no return to idle after result");

endmodule
